### hw/rtl/chff_pkg.sv
// Shared types and constants for the compass heading CORDIC pipeline.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
`timescale 1ns / 1ps

package chff_pkg;

  // Working widths: vector components carry 16 fractional bits plus CORDIC growth.
  localparam int VEC_W   = 35;
  localparam int ANGLE_W = 33;
  localparam int ARC_W   = 30;
  localparam int FRAC_W  = 16;
  localparam int CD_W    = 17;

  // Angles are in units of 1/65536 centidegree.
  localparam logic signed [ANGLE_W-1:0] HALF_TURN = 33'sd1179648000;
  localparam logic signed [ANGLE_W-1:0] FULL_TURN = 33'sd2359296000;
  localparam logic [CD_W-1:0] TURN_CENTIDEG = 17'd36000;

  // One vector in flight through the rotation stages.
  typedef struct packed {
    logic signed [VEC_W-1:0]   u;
    logic signed [VEC_W-1:0]   v;
    logic signed [ANGLE_W-1:0] z;
    logic                      bypass;
  } chff_vec_t;

  // Elementary rotation angle atan(2^-idx) in 1/65536 centidegree.
  function automatic logic [ARC_W-1:0] arc_angle(input int unsigned idx);
    logic [ARC_W-1:0] a;
    case (idx)
      0:  a = 30'd294912000;
      1:  a = 30'd174096719;
      2:  a = 30'd91987925;
      3:  a = 30'd46694507;
      4:  a = 30'd23437865;
      5:  a = 30'd11730358;
      6:  a = 30'd5866610;
      7:  a = 30'd2933484;
      8:  a = 30'd1466764;
      9:  a = 30'd733385;
      10: a = 30'd366693;
      11: a = 30'd183346;
      12: a = 30'd91673;
      13: a = 30'd45837;
      14: a = 30'd22918;
      15: a = 30'd11459;
      16: a = 30'd5730;
      17: a = 30'd2865;
      18: a = 30'd1432;
      19: a = 30'd716;
      20: a = 30'd358;
      21: a = 30'd179;
      22: a = 30'd90;
      23: a = 30'd45;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### hw/rtl/compass_heading_from_field_core.sv
// Top level of the compass heading block: input fold, CORDIC stages, rounding.
// Depends on chff_pkg, chff_pre, chff_stage and chff_post.
//
// Usage: present a tilt-compensated horizontal field sample on mag_x and
// mag_y with in_valid; the transaction completes when in_valid and in_ready
// are both high. Each sample yields exactly one heading_centideg transaction
// on out_valid/out_ready, in arrival order: the heading clockwise from
// magnetic north in hundredths of a degree, 0 to 35999.
// There is one register for the half-plane fold, one per micro-rotation stage,
// and one for wrap and rounding. Throughput is one sample per cycle while
// out_ready stays high; each stage holds one transaction.
// Every stage has its own valid bit and loads when it is empty or its
// successor moves, so a stalled receiver fills bubbles first and then
// backpressures through in_ready without losing or repeating a transaction.
// Synchronous reset clears all valid bits; the pipeline is empty afterward.
`timescale 1ns / 1ps

module compass_heading_from_field_core #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        heading_centideg
);

  chff_pkg::chff_vec_t pipe_data  [CORDIC_STEPS+1];
  logic                pipe_valid [CORDIC_STEPS+1];
  logic                pipe_ready [CORDIC_STEPS+1];

  // Fold into the right half plane.
  chff_pre u_pre (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .out_valid (pipe_valid[0]),
    .out_ready (pipe_ready[0]),
    .out_data  (pipe_data[0])
  );

  // One registered micro-rotation per step.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    chff_stage #(
      .STEP (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[k]),
      .in_ready  (pipe_ready[k]),
      .in_data   (pipe_data[k]),
      .out_valid (pipe_valid[k+1]),
      .out_ready (pipe_ready[k+1]),
      .out_data  (pipe_data[k+1])
    );
  end

  // Wrap, round and drive the result channel.
  chff_post u_post (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (pipe_valid[CORDIC_STEPS]),
    .in_ready         (pipe_ready[CORDIC_STEPS]),
    .in_data          (pipe_data[CORDIC_STEPS]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .heading_centideg (heading_centideg)
  );

endmodule

### hw/rtl/chff_pre.sv
// Input stage: folds the vector into the right half plane and scales it.
// Depends on chff_pkg for the vector type and the half-turn constant.
`timescale 1ns / 1ps

module chff_pre (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [15:0]      mag_x,
  input  logic signed [15:0]      mag_y,
  output logic                    out_valid,
  input  logic                    out_ready,
  output chff_pkg::chff_vec_t     out_data
);

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic signed [16:0] u_int;
  logic signed [16:0] v_int;
  chff_pkg::chff_vec_t data_next;

  // The heading uses -y; a negative x rotates the vector by a half turn first.
  always_comb begin
    x_ext = 17'(mag_x);
    y_ext = 17'(mag_y);
    if (mag_x < 0) begin
      u_int = -x_ext;
      v_int = y_ext;
      data_next.z = chff_pkg::HALF_TURN;
    end else begin
      u_int = x_ext;
      v_int = -y_ext;
      data_next.z = '0;
    end
    data_next.u = {{(chff_pkg::VEC_W - 17 - chff_pkg::FRAC_W){u_int[16]}}, u_int,
                   {chff_pkg::FRAC_W{1'b0}}};
    data_next.v = {{(chff_pkg::VEC_W - 17 - chff_pkg::FRAC_W){v_int[16]}}, v_int,
                   {chff_pkg::FRAC_W{1'b0}}};
    // A vector on the north-south axis needs no rotations.
    data_next.bypass = (mag_y == 16'sd0);
  end

  assign in_ready = !out_valid || out_ready;

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### hw/rtl/chff_stage.sv
// One CORDIC vectoring micro-rotation with its pipeline register.
// Depends on chff_pkg for the vector type and the arctangent table.
`timescale 1ns / 1ps

module chff_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  chff_pkg::chff_vec_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chff_pkg::chff_vec_t out_data
);

  localparam logic signed [chff_pkg::ANGLE_W-1:0] ARC =
    chff_pkg::ANGLE_W'(chff_pkg::arc_angle(STEP));

  logic signed [chff_pkg::VEC_W-1:0] du;
  logic signed [chff_pkg::VEC_W-1:0] dv;
  logic                              v_pos;
  chff_pkg::chff_vec_t               data_next;

  // Rotate toward the x axis, accumulating the angle turned.
  always_comb begin
    du = in_data.v >>> STEP;
    dv = in_data.u >>> STEP;
    v_pos = !in_data.v[chff_pkg::VEC_W-1] && (in_data.v != '0);
    data_next = in_data;
    if (!in_data.bypass) begin
      if (v_pos) begin
        data_next.u = in_data.u + du;
        data_next.v = in_data.v - dv;
        data_next.z = in_data.z + ARC;
      end else begin
        data_next.u = in_data.u - du;
        data_next.v = in_data.v + dv;
        data_next.z = in_data.z - ARC;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

### hw/rtl/chff_post.sv
// Output stage: wraps the angle into one turn and rounds to centidegrees.
// Depends on chff_pkg for the vector type and turn constants.
`timescale 1ns / 1ps

module chff_post (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  chff_pkg::chff_vec_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         heading_centideg
);

  logic signed [chff_pkg::ANGLE_W-1:0] z_wrap;
  logic [chff_pkg::ANGLE_W:0]          z_round;
  logic [chff_pkg::CD_W-1:0]           cd;
  logic [15:0]                         heading_next;

  // Negative angles move up by a full turn; a rounded full turn folds to zero.
  always_comb begin
    if (in_data.z[chff_pkg::ANGLE_W-1]) begin
      z_wrap = in_data.z + chff_pkg::FULL_TURN;
    end else begin
      z_wrap = in_data.z;
    end
    z_round = {1'b0, z_wrap} + (chff_pkg::ANGLE_W + 1)'(1 << (chff_pkg::FRAC_W - 1));
    cd = z_round[chff_pkg::FRAC_W +: chff_pkg::CD_W];
    if (cd >= chff_pkg::TURN_CENTIDEG) begin
      heading_next = 16'(cd - chff_pkg::TURN_CENTIDEG);
    end else begin
      heading_next = 16'(cd);
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      heading_centideg <= heading_next;
    end
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for compass_heading_from_field_core, the CORDIC compass heading block.
// Depends only on the RTL under hw/rtl; it keeps its own fixed-point heading predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned STEPS = 16;
  localparam int unsigned LATENCY = STEPS + 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint UNITS_PER_CD = 65536;
  localparam longint HALF_TURN_UNITS = 64'sd18000 * UNITS_PER_CD;
  localparam longint FULL_TURN_UNITS = 64'sd36000 * UNITS_PER_CD;
  localparam longint TURN_CD = 36000;

  // One accepted sample and the heading it must produce.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        heading;
  } heading_job_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] mag_x = '0;
  logic signed [15:0] mag_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        heading_centideg;

  heading_job_t pending_headings[$];
  heading_job_t oldest;
  int           fail_count = 0;
  int           cycle_count = 0;
  bit           tx_gaps_on = 1'b1;
  bit           rx_stalls_on = 1'b1;

  compass_heading_from_field_core #(
    .CORDIC_STEPS(STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mag_x(mag_x),
    .mag_y(mag_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .heading_centideg(heading_centideg)
  );

  always #1 clk = ~clk;

  // Elementary rotation angles atan(2^-i) in 1/65536 centidegree.
  function automatic longint arc_units(input int i);
    case (i)
      0:  return 294912000;
      1:  return 174096719;
      2:  return 91987925;
      3:  return 46694507;
      4:  return 23437865;
      5:  return 11730358;
      6:  return 5866610;
      7:  return 2933484;
      8:  return 1466764;
      9:  return 733385;
      10: return 366693;
      11: return 183346;
      12: return 91673;
      13: return 45837;
      14: return 22918;
      15: return 11459;
      16: return 5730;
      17: return 2865;
      18: return 1432;
      19: return 716;
      20: return 358;
      21: return 179;
      22: return 90;
      23: return 45;
      default: return 0;
    endcase
  endfunction

  // Heading clockwise from north, atan2(-y, x), by a vectoring CORDIC in 64-bit fixed point.
  function automatic logic [15:0] predict_heading(input logic signed [15:0] x,
                                                  input logic signed [15:0] y);
    longint u;
    longint v;
    longint z;
    longint du;
    longint dv;
    longint cd;
    int     n;
    u = longint'(x) * 65536;
    v = -(longint'(y) * 65536);
    z = 0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (u == 0 && v == 0) begin
      return 16'd0;
    end
    // Fold the left half plane onto the right one.
    if (u < 0) begin
      u = -u;
      v = -v;
      z = HALF_TURN_UNITS;
    end
    if (v != 0) begin
      for (int i = 0; i < n; i++) begin
        du = v >>> i;
        dv = u >>> i;
        if (v > 0) begin
          u = u + du;
          v = v - dv;
          z = z + arc_units(i);
        end else begin
          u = u - du;
          v = v + dv;
          z = z - arc_units(i);
        end
      end
    end
    if (z < 0) begin
      z = z + FULL_TURN_UNITS;
    end
    if (z < 0) begin
      z = 0;
    end
    // Round to the nearest centidegree; a full turn wraps to north.
    cd = (z + UNITS_PER_CD / 2) / UNITS_PER_CD;
    while (cd >= TURN_CD) begin
      cd = cd - TURN_CD;
    end
    return 16'(cd);
  endfunction

  // Drive one sample and record its heading once the transaction completes.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y);
    int unsigned  gap;
    heading_job_t job;
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mag_x <= x;
    mag_y <= y;
    do @(posedge clk); while (!in_ready);
    job.x = x;
    job.y = y;
    job.heading = predict_heading(x, y);
    pending_headings.push_back(job);
  endtask

  // Stop sending and let every outstanding heading come back.
  task automatic wait_for_all_headings();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  // One of the values at the ends of the signed 16-bit range or around zero.
  function automatic logic signed [15:0] corner_value(input int unsigned pick);
    case (pick)
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  // Random sample: full range, scaled down, tiny, on an axis, near north or south, or at the corners.
  task automatic draw_field_sample(output logic signed [15:0] x, output logic signed [15:0] y);
    int unsigned kind;
    kind = $urandom_range(0, 9);
    x = 16'($urandom);
    y = 16'($urandom);
    case (kind)
      4, 5: begin
        x = x >>> $urandom_range(0, 15);
        y = y >>> $urandom_range(0, 15);
      end
      6: begin
        x = 16'(int'($urandom_range(0, 8)) - 4);
        y = 16'(int'($urandom_range(0, 8)) - 4);
      end
      7: begin
        if ($urandom_range(0, 1) != 0) begin
          y = '0;
        end else begin
          x = '0;
        end
      end
      8: begin
        // Large x with tiny y lands next to the wrap at north or next to south.
        x = ($urandom_range(0, 1) != 0) ? (x | 16'sh4000) & 16'sh7fff : x | 16'sh8000;
        y = 16'(int'($urandom_range(0, 6)) - 3);
      end
      9: begin
        x = corner_value($urandom_range(0, 5));
        y = corner_value($urandom_range(0, 5));
      end
      default: begin
      end
    endcase
  endtask

  // Zero vector and both axes, including the most negative components.
  task automatic test_zero_and_axes();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd1);
    send_sample(16'sd0, -16'sd1);
    send_sample(16'sd0, 16'sd32767);
    send_sample(16'sd0, -16'sd32768);
  endtask

  // Corners of the input range and the smallest diagonal vectors.
  task automatic test_corners();
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(-16'sd1, 16'sd1);
    send_sample(16'sd1, -16'sd1);
  endtask

  // Samples just either side of north and of south; just west of north rounds up to a full turn and must wrap to zero.
  task automatic test_north_wrap();
    send_sample(16'sd32767, 16'sd1);
    send_sample(16'sd32767, -16'sd1);
    send_sample(16'sd30000, 16'sd2);
    send_sample(-16'sd32768, 16'sd1);
    send_sample(-16'sd32768, -16'sd1);
  endtask

  // Mixed random samples with gaps on the sender and stalls on the receiver.
  task automatic test_random_traffic(input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    repeat (count) begin
      draw_field_sample(x, y);
      send_sample(x, y);
    end
  endtask

  // Back-to-back transactions with the receiver always ready.
  task automatic test_full_rate(input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (count) begin
      draw_field_sample(x, y);
      send_sample(x, y);
    end
  endtask

  // Full-rate bursts into a stalling receiver, each followed by a complete drain.
  task automatic test_backpressure_bursts(input int bursts, input int count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b1;
    repeat (bursts) begin
      repeat (count) begin
        draw_field_sample(x, y);
        send_sample(x, y);
      end
      wait_for_all_headings();
    end
  endtask

  // Compare each heading transaction with the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_headings.size() == 0) begin
        $error("heading_centideg: unexpected transaction, actual %0d", heading_centideg);
        fail_count++;
      end else begin
        oldest = pending_headings.pop_front();
        if (heading_centideg !== oldest.heading) begin
          $error("heading_centideg (mag_x=%0d mag_y=%0d): expected %0d, actual %0d",
                 oldest.x, oldest.y, oldest.heading, heading_centideg);
          fail_count++;
        end
      end
    end
  end

  // Receiver: a random stall before each transaction, then hold ready until it completes.
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 4) : 0;
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("compass_heading_from_field_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_and_axes();
    test_corners();
    test_north_wrap();
    wait_for_all_headings();
    test_random_traffic(800);
    test_full_rate(300);
    test_backpressure_bursts(3, 100);
    test_random_traffic(200);

    wait_for_all_headings();
    repeat (LATENCY + 8) @(posedge clk);
    if (fail_count == 0 && pending_headings.size() == 0) begin
      $display("compass_heading_from_field_core test passed");
    end else begin
      $display("compass_heading_from_field_core test failed");
    end
    $finish;
  end

endmodule
